@@ src/prfm_pkg.sv @@
// ----------------------------------------------------------------------------
// prfm_pkg
// Types and constants shared by the pin and rake frame monitor.
// ----------------------------------------------------------------------------
package prfm_pkg;

  localparam int unsigned CompW    = 8;   // width of one color sample
  localparam int unsigned ThrW     = 9;   // width of a signed threshold
  localparam int unsigned SettleW  = 8;   // width of the settle count
  localparam int unsigned CountW   = 8;   // width of the frame counter
  localparam int unsigned IndexW   = 4;   // width of point_index
  localparam int unsigned MaskW    = 10;  // width of the reported pin mask
  localparam int unsigned CfgIdxW  = 3;   // width of a register index
  localparam int unsigned CfgDataW = 9;   // width of configuration write data
  localparam int unsigned DarkW    = 2;   // dark tests of one rake point, 0..3

  localparam logic [CountW-1:0] CountMax = '1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIN_RED_MIN    = 3'd0,
    REG_PIN_GREEN_MIN  = 3'd1,
    REG_PIN_BLUE_MIN   = 3'd2,
    REG_RAKE_RED_MAX   = 3'd3,
    REG_RAKE_GREEN_MAX = 3'd4,
    REG_RAKE_BLUE_MAX  = 3'd5,
    REG_SETTLE_FRAMES  = 3'd6
  } cfg_reg_t;

  // Sweep cycle phases
  typedef enum logic [2:0] {
    PH_UNKNOWN   = 3'd0,
    PH_READY     = 3'd1,
    PH_RAKE_DOWN = 3'd2,
    PH_SWEEPING  = 3'd3,
    PH_RAKE_UP   = 3'd4
  } phase_t;

  // Threshold registers as seen by the point evaluator
  typedef struct packed {
    logic signed [ThrW-1:0] pin_red_min;
    logic signed [ThrW-1:0] pin_green_min;
    logic signed [ThrW-1:0] pin_blue_min;
    logic signed [ThrW-1:0] rake_red_max;
    logic signed [ThrW-1:0] rake_green_max;
    logic signed [ThrW-1:0] rake_blue_max;
  } thresholds_t;

  // Point evaluation result
  typedef struct packed {
    logic             pin_up;
    logic [DarkW-1:0] rake_dark;
  } point_eval_t;

  // Phase tracker status after one frame step
  typedef struct packed {
    logic              report;
    phase_t            phase;
    logic [CountW-1:0] frames;
  } phase_status_t;

  // One result item
  typedef struct packed {
    logic              report_valid;
    logic [MaskW-1:0]  pins_standing;
    logic              rake_is_down;
    logic [2:0]        phase;
    logic [CountW-1:0] frames_in_phase;
  } result_t;

endpackage

@@ src/prfm_if.sv @@
// ----------------------------------------------------------------------------
// prfm_if
// Valid/ready channels of the pin and rake frame monitor: sample input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface prfm_sample_if;
  logic                         valid;
  logic                         ready;
  logic [prfm_pkg::IndexW-1:0]  point_index;
  logic [prfm_pkg::CompW-1:0]   red;
  logic [prfm_pkg::CompW-1:0]   green;
  logic [prfm_pkg::CompW-1:0]   blue;
  logic                         frame_end;

  modport source (output valid, point_index, red, green, blue, frame_end, input ready);
  modport sink   (input valid, point_index, red, green, blue, frame_end, output ready);
endinterface

interface prfm_result_if;
  logic                         valid;
  logic                         ready;
  logic                         report_valid;
  logic [prfm_pkg::MaskW-1:0]   pins_standing;
  logic                         rake_is_down;
  logic [2:0]                   phase;
  logic [prfm_pkg::CountW-1:0]  frames_in_phase;

  modport source (output valid, report_valid, pins_standing, rake_is_down, phase,
                  frames_in_phase, input ready);
  modport sink   (input valid, report_valid, pins_standing, rake_is_down, phase,
                  frames_in_phase, output ready);
endinterface

interface prfm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prfm_pkg::CfgIdxW-1:0]  index;
  logic [prfm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/prfm_point_eval.sv @@
// ----------------------------------------------------------------------------
// prfm_point_eval
// Threshold tests for one sample: pin brightness vote and rake dark count.
// ----------------------------------------------------------------------------
module prfm_point_eval (
  input  prfm_pkg::thresholds_t          thr,
  input  logic [prfm_pkg::CompW-1:0]     red,
  input  logic [prfm_pkg::CompW-1:0]     green,
  input  logic [prfm_pkg::CompW-1:0]     blue,
  output prfm_pkg::point_eval_t          eval
);
  import prfm_pkg::*;

  logic signed [ThrW-1:0] r_s, g_s, b_s;
  logic                   r_hi, g_hi, b_hi;
  logic                   r_lo, g_lo, b_lo;

  // widen samples to signed threshold width
  assign r_s = $signed({1'b0, red});
  assign g_s = $signed({1'b0, green});
  assign b_s = $signed({1'b0, blue});

  // bright tests for pins, dark tests for rake points
  assign r_hi = (thr.pin_red_min   <= r_s);
  assign g_hi = (thr.pin_green_min <= g_s);
  assign b_hi = (thr.pin_blue_min  <= b_s);
  assign r_lo = (thr.rake_red_max   >= r_s);
  assign g_lo = (thr.rake_green_max >= g_s);
  assign b_lo = (thr.rake_blue_max  >= b_s);

  // two of three channels bright makes a standing pin
  assign eval.pin_up    = (r_hi & g_hi) | (r_hi & b_hi) | (g_hi & b_hi);
  assign eval.rake_dark = DarkW'(r_lo) + DarkW'(g_lo) + DarkW'(b_lo);

endmodule

@@ src/prfm_phase_fsm.sv @@
// ----------------------------------------------------------------------------
// prfm_phase_fsm
// Five-phase sweep cycle tracker with saturating frame counter, stepped once
// per frame end.
// ----------------------------------------------------------------------------
module prfm_phase_fsm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            down,
  input  logic [prfm_pkg::SettleW-1:0]    settle,
  output prfm_pkg::phase_status_t         status
);
  import prfm_pkg::*;

  phase_t            phase, phase_next;
  logic [CountW-1:0] frame_counter, frame_counter_next;
  logic [CountW-1:0] count_inc;
  logic              settled;

  // count first, saturating, then judge the settle time
  assign count_inc = (frame_counter == CountMax) ? frame_counter : frame_counter + 1'b1;
  assign settled   = (count_inc > settle);

  // next state
  always_comb begin
    phase_next         = phase;
    frame_counter_next = count_inc;
    unique case (phase)
      PH_UNKNOWN: begin
        phase_next         = down ? PH_RAKE_DOWN : PH_READY;
        frame_counter_next = '0;
      end
      PH_READY: begin
        if (down) begin
          phase_next         = PH_RAKE_DOWN;
          frame_counter_next = '0;
        end
      end
      PH_RAKE_DOWN: begin
        if (!down && settled) begin
          phase_next         = PH_SWEEPING;
          frame_counter_next = '0;
        end
      end
      PH_SWEEPING: begin
        if (down && settled) begin
          phase_next         = PH_RAKE_UP;
          frame_counter_next = '0;
        end
      end
      PH_RAKE_UP: begin
        if (!down) begin
          phase_next = PH_READY;
        end
      end
      default: begin
        phase_next = PH_UNKNOWN;
      end
    endcase
  end

  // outputs
  always_comb begin
    status.report = (phase == PH_READY) && down;
    status.phase  = phase_next;
    status.frames = frame_counter_next;
  end

  // hold state between frame ends
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_UNKNOWN;
      frame_counter <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_counter <= frame_counter_next;
    end
  end

endmodule

@@ src/pin_and_rake_frame_monitor_top.sv @@
// ----------------------------------------------------------------------------
// pin_and_rake_frame_monitor_top
// Per-frame pin mask and rake detection with sweep cycle tracking.
// ----------------------------------------------------------------------------
// One sample item is taken every clock cycle while samples.ready is high. Each
// sample is tested against the thresholds and folded into the frame's pin mask
// and rake dark counts in the cycle it is accepted; a sample marked frame_end
// also steps the sweep phase tracker and loads one result item into the output
// register. A second output entry absorbs one result while the sink stalls, so
// input stalls only when both entries are full. No clearing pass follows reset;
// the block is ready in the first cycle.
// ----------------------------------------------------------------------------
module pin_and_rake_frame_monitor_top #(
  parameter int unsigned PIN_COUNT   = 10,
  parameter int unsigned RAKE_POINTS = 2
) (
  input  logic         clk,
  input  logic         rst,
  prfm_sample_if.sink  samples,
  prfm_result_if.source results,
  prfm_cfg_if.sink     cfg
);
  import prfm_pkg::*;

  localparam int unsigned PtW     = 5;
  localparam int unsigned DownMin = 3 * RAKE_POINTS - 1;
  localparam int unsigned TotalW  = $clog2(3 * RAKE_POINTS + 1);

  // configuration registers
  thresholds_t        thr;
  logic [SettleW-1:0] settle_frames;

  // frame accumulation
  logic [PIN_COUNT-1:0] pin_up_mask, pin_up_mask_next;
  logic [DarkW-1:0]     rake_dark_tally [RAKE_POINTS];
  logic [DarkW-1:0]     tally_upd       [RAKE_POINTS];
  logic [PIN_COUNT-1:0] pin_sel;
  logic [RAKE_POINTS-1:0] rake_sel;
  logic [TotalW-1:0]    dark_total;
  logic                 rake_dropped;

  point_eval_t          eval;
  phase_status_t        status;
  logic                 accept, push, pop;
  logic [MaskW-1:0]     mask_out;
  result_t              result_new;

  // output buffer
  result_t              out_main, out_skid;
  logic                 main_valid, skid_valid;

  // ---- configuration writes ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.pin_red_min    <= '1;
      thr.pin_green_min  <= '1;
      thr.pin_blue_min   <= '1;
      thr.rake_red_max   <= '1;
      thr.rake_green_max <= '1;
      thr.rake_blue_max  <= '1;
      settle_frames      <= SettleW'(6);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PIN_RED_MIN:    thr.pin_red_min    <= $signed(cfg.data);
        REG_PIN_GREEN_MIN:  thr.pin_green_min  <= $signed(cfg.data);
        REG_PIN_BLUE_MIN:   thr.pin_blue_min   <= $signed(cfg.data);
        REG_RAKE_RED_MAX:   thr.rake_red_max   <= $signed(cfg.data);
        REG_RAKE_GREEN_MAX: thr.rake_green_max <= $signed(cfg.data);
        REG_RAKE_BLUE_MAX:  thr.rake_blue_max  <= $signed(cfg.data);
        REG_SETTLE_FRAMES:  settle_frames      <= cfg.data[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // ---- sample evaluation ----
  prfm_point_eval u_eval (
    .thr   (thr),
    .red   (samples.red),
    .green (samples.green),
    .blue  (samples.blue),
    .eval  (eval)
  );

  assign accept = samples.valid && samples.ready;
  assign push   = accept && samples.frame_end;

  // decode the point: pin 1 sits in the top mask bit
  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      pin_sel[i] = ({1'b0, samples.point_index} == PtW'(PIN_COUNT - 1 - i));
    end
    for (int j = 0; j < RAKE_POINTS; j++) begin
      rake_sel[j] = ({1'b0, samples.point_index} == PtW'(PIN_COUNT + j));
    end
  end

  // replace the selected pin bit or rake count with this sample
  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      pin_up_mask_next[i] = pin_sel[i] ? eval.pin_up : pin_up_mask[i];
    end
    for (int j = 0; j < RAKE_POINTS; j++) begin
      tally_upd[j] = rake_sel[j] ? eval.rake_dark : rake_dark_tally[j];
    end
  end

  // rake is down when nearly every dark test holds
  always_comb begin
    dark_total = '0;
    for (int j = 0; j < RAKE_POINTS; j++) begin
      dark_total = dark_total + TotalW'(tally_upd[j]);
    end
    rake_dropped = (dark_total >= TotalW'(DownMin));
  end

  // accumulate within a frame, clear at its end
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_up_mask <= '0;
      for (int j = 0; j < RAKE_POINTS; j++) begin
        rake_dark_tally[j] <= '0;
      end
    end else if (accept) begin
      if (samples.frame_end) begin
        pin_up_mask <= '0;
        for (int j = 0; j < RAKE_POINTS; j++) begin
          rake_dark_tally[j] <= '0;
        end
      end else begin
        pin_up_mask <= pin_up_mask_next;
        for (int j = 0; j < RAKE_POINTS; j++) begin
          rake_dark_tally[j] <= tally_upd[j];
        end
      end
    end
  end

  // ---- sweep phase tracking ----
  prfm_phase_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (push),
    .down   (rake_dropped),
    .settle (settle_frames),
    .status (status)
  );

  // fit the pin mask to the reported width
  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < PIN_COUNT) begin : g_bit
      assign mask_out[b] = pin_up_mask_next[b];
    end else begin : g_pad
      assign mask_out[b] = 1'b0;
    end
  end

  always_comb begin
    result_new.report_valid    = status.report;
    result_new.pins_standing   = mask_out;
    result_new.rake_is_down    = rake_dropped;
    result_new.phase           = status.phase;
    result_new.frames_in_phase = status.frames;
  end

  // ---- output register with skid entry ----
  assign samples.ready = !skid_valid;
  assign pop           = main_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || pop) begin
        main_valid <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      out_main <= skid_valid ? out_skid : result_new;
    end
    if (push && main_valid && !pop) begin
      out_skid <= result_new;
    end
  end

  assign results.valid           = main_valid;
  assign results.report_valid    = out_main.report_valid;
  assign results.pins_standing   = out_main.pins_standing;
  assign results.rake_is_down    = out_main.rake_is_down;
  assign results.phase           = out_main.phase;
  assign results.frames_in_phase = out_main.frames_in_phase;

  // ---- assertions ----
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry full while output register empty");

  a_report_enters_rake_down: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.report_valid) |->
      (results.phase == PH_RAKE_DOWN && results.frames_in_phase == '0))
    else $error("report without entering rake down with a cleared counter");

  a_ready_rake_up: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.phase == PH_READY) |-> !results.rake_is_down)
    else $error("ready phase reported with rake down");

  a_phase_known: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.phase != PH_UNKNOWN))
    else $error("result carries unknown phase after a frame step");

endmodule

@@ dv/pin_and_rake_frame_monitor_top_test.sv @@
// ----------------------------------------------------------------------------
// pin_and_rake_frame_monitor_top_test
// Self-checking bench for the pin and rake frame monitor. A directed table
// covers reset thresholds, extremes, repeated and unknown points and one trip
// around the sweep cycle. Random frames then run under several threshold
// settings and handshake idling patterns. A final long run of quiet frames
// drives the frame counter into saturation. Every result item is checked against
// its table entry or a cycle-free model of the frame logic kept in this bench.
// ----------------------------------------------------------------------------
module pin_and_rake_frame_monitor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prfm_pkg::*;

  localparam int PinCount    = 10;
  localparam int RakePoints  = 2;
  localparam int StallLimit  = 2000;
  localparam int SettleDelay = 4;

  typedef struct packed {
    logic [IndexW-1:0] point;
    logic [CompW-1:0]  red;
    logic [CompW-1:0]  green;
    logic [CompW-1:0]  blue;
    logic              frame_end;
  } sample_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_op_t;

  typedef struct {
    row_op_t             op;
    sample_t             item;
    bit                  known;
    result_t             want;
    cfg_reg_t            sel;
    logic [CfgDataW-1:0] val;
  } step_row_t;

  logic clk;
  logic rst;

  prfm_sample_if smp ();
  prfm_result_if res ();
  prfm_cfg_if    cfg_ch ();

  pin_and_rake_frame_monitor_top #(
    .PIN_COUNT  (PinCount),
    .RAKE_POINTS(RakePoints)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(smp),
    .results(res),
    .cfg    (cfg_ch)
  );

  // Frame model state, at reset values
  logic signed [ThrW-1:0] pin_min [3]  = '{default: '1};
  logic signed [ThrW-1:0] rake_max [3] = '{default: '1};
  logic [SettleW-1:0]     settle       = 8'd6;
  phase_t                 sweep_phase  = PH_UNKNOWN;
  logic [CountW-1:0]      frame_count  = '0;
  logic [MaskW-1:0]       pins_up      = '0;
  logic [DarkW-1:0]       dark_tests [RakePoints] = '{default: '0};

  result_t expected_frames[$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Fold one sample into the frame; on frame end step the sweep cycle
  function automatic bit fold_sample(input sample_t s, output result_t frame_out);
    logic [CompW-1:0] chan [3];
    int               lit;
    int               dark;
    int               dark_total;
    bit               down;
    bit               report;
    chan = '{s.red, s.green, s.blue};
    lit  = 0;
    dark = 0;
    for (int c = 0; c < 3; c++) begin
      if (int'(chan[c]) >= pin_min[c]) lit++;
      if (int'(chan[c]) <= rake_max[c]) dark++;
    end
    if (s.point < PinCount) begin
      pins_up[PinCount-1-s.point] = (lit >= 2);
    end else if (s.point < PinCount + RakePoints) begin
      dark_tests[s.point-PinCount] = DarkW'(dark);
    end
    frame_out = '0;
    if (!s.frame_end) return 1'b0;

    dark_total = 0;
    foreach (dark_tests[i]) dark_total += dark_tests[i];
    down   = (dark_total >= 3 * RakePoints - 1);
    report = 1'b0;
    if (frame_count != CountMax) frame_count++;
    case (sweep_phase)
      PH_UNKNOWN: begin
        sweep_phase = down ? PH_RAKE_DOWN : PH_READY;
        frame_count = '0;
      end
      PH_READY: begin
        if (down) begin
          report      = 1'b1;
          sweep_phase = PH_RAKE_DOWN;
          frame_count = '0;
        end
      end
      PH_RAKE_DOWN: begin
        if (!down && frame_count > settle) begin
          sweep_phase = PH_SWEEPING;
          frame_count = '0;
        end
      end
      PH_SWEEPING: begin
        if (down && frame_count > settle) begin
          sweep_phase = PH_RAKE_UP;
          frame_count = '0;
        end
      end
      PH_RAKE_UP: begin
        if (!down) sweep_phase = PH_READY;
      end
      default: sweep_phase = PH_UNKNOWN;
    endcase
    frame_out.report_valid    = report;
    frame_out.pins_standing   = pins_up;
    frame_out.rake_is_down    = down;
    frame_out.phase           = sweep_phase;
    frame_out.frames_in_phase = frame_count;
    pins_up    = '0;
    dark_tests = '{default: '0};
    return 1'b1;
  endfunction

  function automatic result_t frame_want(bit rep, logic [MaskW-1:0] mask, bit down,
                                         phase_t ph, int cnt);
    result_t w;
    w.report_valid    = rep;
    w.pins_standing   = mask;
    w.rake_is_down    = down;
    w.phase           = ph;
    w.frames_in_phase = CountW'(cnt);
    return w;
  endfunction

  function automatic step_row_t sample_row(int pt, int r, int g, int b, bit fe,
                                           bit known = 0, result_t want = '0);
    step_row_t row;
    row.op    = ROW_SAMPLE;
    row.item  = '{point: IndexW'(pt), red: CompW'(r), green: CompW'(g),
                  blue: CompW'(b), frame_end: fe};
    row.known = known;
    row.want  = want;
    row.sel   = REG_PIN_RED_MIN;
    row.val   = '0;
    return row;
  endfunction

  function automatic step_row_t write_row(cfg_reg_t sel, logic [CfgDataW-1:0] val);
    step_row_t row;
    row       = sample_row(0, 0, 0, 0, 0);
    row.op    = ROW_WRITE;
    row.sel   = sel;
    row.val   = val;
    return row;
  endfunction

  // Random level strictly below bound, or at or above it; any level if impossible
  function automatic logic [CompW-1:0] level_split(int bound, bit below);
    int lo;
    int hi;
    if (below) begin
      lo = 0;
      hi = bound - 1;
    end else begin
      lo = bound;
      hi = 255;
    end
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if (hi < lo) begin
      lo = 0;
      hi = 255;
    end
    return CompW'($urandom_range(hi, lo));
  endfunction

  // Present one item, hold it until taken, then record its expected result
  task automatic send_sample(sample_t s, bit known = 0, result_t want = '0);
    result_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid       <= 1'b1;
    smp.point_index <= s.point;
    smp.red         <= s.red;
    smp.green       <= s.green;
    smp.blue        <= s.blue;
    smp.frame_end   <= s.frame_end;
    do @(posedge clk); while (!(smp.valid && smp.ready));
    if (fold_sample(s, guess)) expected_frames.push_back(known ? want : guess);
  endtask

  // Drop the sample stream and wait for every pending result to drain
  task automatic wait_idle();
    smp.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SettleDelay) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (sel <= REG_PIN_BLUE_MIN) pin_min[sel] = val;
    else if (sel <= REG_RAKE_BLUE_MAX) rake_max[sel-REG_RAKE_RED_MAX] = val;
    else if (sel == REG_SETTLE_FRAMES) settle = val[SettleW-1:0];
  endtask

  // Random thresholds with extremes mixed in, plus the given settle count
  task automatic load_settings(int settle_val);
    logic [CfgDataW-1:0] pick;
    for (int i = 0; i <= REG_RAKE_BLUE_MAX; i++) begin
      case ($urandom_range(9))
        0:       pick = '1;
        1:       pick = 9'd255;
        2:       pick = 9'd0;
        default: pick = CfgDataW'($urandom_range(220, 40));
      endcase
      write_reg(cfg_reg_t'(i), pick);
    end
    write_reg(REG_SETTLE_FRAMES, CfgDataW'(settle_val));
  endtask

  // One frame: mostly shuffled well-formed points, sometimes loose noise
  task automatic send_frame(output int sent);
    int         pts[$];
    sample_t    s;
    bit         want_down;
    logic [7:0] chan [3];
    sent = 0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(6, 1)) begin
        s.point     = IndexW'($urandom_range(15, 0));
        s.red       = CompW'($urandom_range(255, 0));
        s.green     = CompW'($urandom_range(255, 0));
        s.blue      = CompW'($urandom_range(255, 0));
        s.frame_end = ($urandom_range(3) == 0);
        send_sample(s);
        sent++;
      end
      return;
    end
    for (int p = 0; p < PinCount + RakePoints; p++) begin
      if ($urandom_range(19) != 0) pts.push_back(p);
    end
    if ($urandom_range(7) == 0) pts.push_back($urandom_range(PinCount + RakePoints - 1, 0));
    if ($urandom_range(11) == 0) pts.push_back($urandom_range(15, PinCount + RakePoints));
    if (pts.size() == 0) pts.push_back(15);
    pts.shuffle();
    want_down = $urandom_range(1);
    foreach (pts[i]) begin
      for (int c = 0; c < 3; c++) begin
        if (pts[i] < PinCount) begin
          chan[c] = level_split(pin_min[c], $urandom_range(1));
        end else begin
          chan[c] = level_split(int'(rake_max[c]) + 1,
                                $urandom_range(9) < (want_down ? 9 : 4));
        end
      end
      s.point     = IndexW'(pts[i]);
      s.red       = chan[0];
      s.green     = chan[1];
      s.blue      = chan[2];
      s.frame_end = (i == pts.size() - 1);
      send_sample(s);
      sent++;
    end
  endtask

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result item with no frame pending");
      end else begin
        want = expected_frames.pop_front();
        if (res.report_valid !== want.report_valid)
          report_mismatch($sformatf("report_valid %0b, want %0b",
                                    res.report_valid, want.report_valid));
        if (res.pins_standing !== want.pins_standing)
          report_mismatch($sformatf("pins_standing %h, want %h",
                                    res.pins_standing, want.pins_standing));
        if (res.rake_is_down !== want.rake_is_down)
          report_mismatch($sformatf("rake_is_down %0b, want %0b",
                                    res.rake_is_down, want.rake_is_down));
        if (res.phase !== want.phase)
          report_mismatch($sformatf("phase %0d, want %0d", res.phase, want.phase));
        if (res.frames_in_phase !== want.frames_in_phase)
          report_mismatch($sformatf("frames_in_phase %0d, want %0d",
                                    res.frames_in_phase, want.frames_in_phase));
      end
    end
    res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no item moves for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < StallLimit) begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    step_row_t directed_steps[$];
    sample_t   s;
    int        sent;
    int        mode_items;

    rst             <= 1'b1;
    smp.valid       <= 1'b0;
    smp.point_index <= '0;
    smp.red         <= '0;
    smp.green       <= '0;
    smp.blue        <= '0;
    smp.frame_end   <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_PIN_RED_MIN;
    cfg_ch.data     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed_steps = {
      // reset thresholds: any delivered pin stands, no rake test holds
      sample_row(0, 0, 0, 0, 0),
      sample_row(10, 0, 0, 0, 0),
      write_row(REG_PIN_RED_MIN, 9'd255),
      write_row(REG_PIN_GREEN_MIN, 9'd255),
      write_row(REG_PIN_BLUE_MIN, 9'd255),
      write_row(REG_RAKE_RED_MAX, 9'd255),
      write_row(REG_RAKE_GREEN_MAX, 9'd255),
      write_row(REG_RAKE_BLUE_MAX, 9'd255),
      write_row(REG_SETTLE_FRAMES, 9'd0),
      sample_row(11, 0, 0, 0, 1, 1, frame_want(0, 10'h200, 0, PH_READY, 0)),
      sample_row(9, 255, 255, 0, 1, 1, frame_want(0, 10'h001, 0, PH_READY, 1)),
      // unknown indexes still close the frame
      sample_row(15, 170, 85, 170, 1, 1, frame_want(0, 10'h000, 0, PH_READY, 2)),
      sample_row(12, 85, 170, 85, 1, 1, frame_want(0, 10'h000, 0, PH_READY, 3)),
      // repeated pin replaces the earlier sample; rake drops while ready
      sample_row(0, 255, 255, 0, 0),
      sample_row(1, 255, 0, 0, 0),
      sample_row(2, 255, 255, 255, 0),
      sample_row(2, 0, 0, 0, 0),
      sample_row(10, 0, 0, 0, 0),
      sample_row(11, 0, 0, 255, 1, 1, frame_want(1, 10'h200, 1, PH_RAKE_DOWN, 0)),
      sample_row(10, 255, 255, 255, 1, 1, frame_want(0, 10'h000, 0, PH_SWEEPING, 0)),
      sample_row(10, 0, 0, 0, 0),
      sample_row(11, 0, 0, 0, 1, 1, frame_want(0, 10'h000, 1, PH_RAKE_UP, 0)),
      sample_row(5, 255, 255, 255, 1, 1, frame_want(0, 10'h010, 0, PH_READY, 1)),
      // rake threshold of -1 never holds; pin threshold of 0 always does
      write_row(REG_RAKE_RED_MAX, 9'h1FF),
      write_row(REG_PIN_RED_MIN, 9'd0),
      sample_row(10, 0, 0, 0, 0),
      sample_row(11, 0, 0, 0, 1, 1, frame_want(0, 10'h000, 0, PH_READY, 2)),
      sample_row(3, 0, 0, 0, 1, 1, frame_want(0, 10'h000, 0, PH_READY, 3))
    };

    foreach (directed_steps[i]) begin
      if (directed_steps[i].op == ROW_WRITE)
        write_reg(directed_steps[i].sel, directed_steps[i].val);
      else
        send_sample(directed_steps[i].item, directed_steps[i].known, directed_steps[i].want);
    end

    // Random frames under each idling pattern
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          load_settings(0);
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
          load_settings($urandom_range(4, 1));
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
          load_settings(254);
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
          load_settings($urandom_range(6, 0));
        end
      endcase
      mode_items = 0;
      while (mode_items < 30) begin
        send_frame(sent);
        mode_items += sent;
      end
    end

    // Long quiet run: rake never dark, so the frame counter saturates
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_settings(0);
    write_reg(REG_RAKE_RED_MAX, '1);
    write_reg(REG_RAKE_GREEN_MAX, '1);
    write_reg(REG_RAKE_BLUE_MAX, '1);
    repeat (260) begin
      s.point     = IndexW'($urandom_range(PinCount - 1, 0));
      s.red       = CompW'($urandom_range(255, 0));
      s.green     = CompW'($urandom_range(255, 0));
      s.blue      = CompW'($urandom_range(255, 0));
      s.frame_end = 1'b1;
      send_sample(s);
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
